### sv/pad_pkg.sv
// ----------------------------------------------------------------------------
// pad_pkg
// Shared widths, codes, types and the square-root step for the point/axis
// distance block.
// ----------------------------------------------------------------------------
package pad_pkg;

    localparam int COORD_W     = 32;
    localparam int FRAC_BITS   = 16;
    localparam int IN_DATA_W   = 3 * COORD_W;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int PROD_W      = DIFF_W + COORD_W;
    localparam int DOT_W       = PROD_W + 1;
    localparam int GUARD_BITS  = 8;
    localparam int UNIT_FRAC   = 30;
    localparam int G_SHIFT     = UNIT_FRAC - GUARD_BITS;
    localparam int G_W         = DOT_W - G_SHIFT;
    localparam int GMAG_W      = 42;
    localparam int GHALF_W     = GMAG_W / 2;
    localparam int G2_W        = 2 * GMAG_W;
    localparam int RAD_W       = SQ_W + 2 * GUARD_BITS;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 3;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int Q_W         = DOT_W - UNIT_FRAC;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int NORM_ACC_W  = 64;
    localparam int NORM_ROOT_N = NORM_ACC_W / 2;
    localparam int NUM_W       = 61;
    localparam int QUO_W       = 31;
    localparam int CNT_W       = 6;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z   = 3'd6;

    localparam logic [1:0] MODE_ORIGIN = 2'd0;
    localparam logic [1:0] MODE_PERP   = 2'd1;
    localparam logic [1:0] MODE_ALONG  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [COORD_W-1:0] DIST_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] DIST_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] AXIS_Z_RESET = COORD_W'(64'd1 << FRAC_BITS);

    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef struct packed {
        diff_t dx;
        diff_t dy;
        diff_t dz;
        logic  last;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] along;
        logic                      along_sat;
        logic                      last;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    typedef enum logic [2:0] {
        NORM_IDLE,
        NORM_SHIFT,
        NORM_SQUARE,
        NORM_ROOT,
        NORM_DIVIDE
    } norm_state_t;

    // one radix-2 digit of the restoring integer square root
    function automatic sqrt_t sqrt_step(input logic [REM_W-1:0]  rem,
                                        input logic [ROOT_W-1:0] root,
                                        input logic [1:0]        pair);
        logic [REM_W-1:0] rs;
        logic [REM_W-1:0] trial;
        sqrt_t            r;
        rs    = {rem[REM_W-3:0], pair};
        trial = {1'b0, root, 2'b01};
        if (rs >= trial) begin
            r.rem  = rs - trial;
            r.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = rs;
            r.root = {root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [DIFF_W-1:0] diff_mag(input diff_t d);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

endpackage

### sv/pad_norm.sv
// ----------------------------------------------------------------------------
// pad_norm
// Sequential axis normaliser: align, sum of squares, root, three divides.
// ----------------------------------------------------------------------------
module pad_norm import pad_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic restart,
    input  vec_t axis,
    output vec_t unit,
    output logic busy
);

    norm_state_t              state_reg, state_next;
    logic                     stale_reg, stale_next;
    logic [COORD_W-1:0]       mag_reg [3];
    logic [COORD_W-1:0]       mag_next [3];
    logic                     neg_reg [3];
    logic                     neg_next [3];
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [1:0]               comp_reg, comp_next;
    logic [NORM_ACC_W-1:0]    acc_reg, acc_next;
    sqrt_t                    sq_reg, sq_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [COORD_W-1:0]       drem_reg, drem_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic signed [COORD_W-1:0] unit_reg [3];
    logic signed [COORD_W-1:0] unit_next [3];

    logic [COORD_W-1:0]       mx;
    logic [COORD_W:0]         r2;
    logic [QUO_W-1:0]         uq;
    logic                     qb;

    always_comb begin
        mx = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        if (mag_reg[2] > mx) begin
            mx = mag_reg[2];
        end
    end

    always_comb begin
        state_next = state_reg;
        stale_next = stale_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        num_next   = num_reg;
        drem_next  = drem_reg;
        quo_next   = quo_reg;
        unit_next  = unit_reg;
        r2 = {drem_reg, num_reg[NUM_W-1]};
        qb = (r2 >= {1'b0, sq_reg.root[COORD_W-1:0]});
        uq = {quo_reg[QUO_W-2:0], qb};
        if (restart) begin
            stale_next = 1'b1;
            state_next = NORM_IDLE;
        end else begin
            unique case (state_reg)
                NORM_IDLE: begin
                    if (stale_reg) begin
                        mag_next[0] = axis.x[COORD_W-1] ? COORD_W'(-axis.x) : COORD_W'(axis.x);
                        mag_next[1] = axis.y[COORD_W-1] ? COORD_W'(-axis.y) : COORD_W'(axis.y);
                        mag_next[2] = axis.z[COORD_W-1] ? COORD_W'(-axis.z) : COORD_W'(axis.z);
                        neg_next[0] = axis.x[COORD_W-1];
                        neg_next[1] = axis.y[COORD_W-1];
                        neg_next[2] = axis.z[COORD_W-1];
                        unit_next[0] = '0;
                        unit_next[1] = '0;
                        unit_next[2] = '0;
                        stale_next = 1'b0;
                        state_next = NORM_SHIFT;
                    end
                end
                NORM_SHIFT: begin
                    comp_next = '0;
                    acc_next  = '0;
                    if (mx == '0) begin
                        state_next = NORM_IDLE;
                    end else if (mx[COORD_W-1]) begin
                        for (int i = 0; i < 3; i++) begin
                            mag_next[i] = mag_reg[i] >> 1;
                        end
                        state_next = NORM_SQUARE;
                    end else if (!mx[UNIT_FRAC]) begin
                        for (int i = 0; i < 3; i++) begin
                            mag_next[i] = mag_reg[i] << 1;
                        end
                    end else begin
                        state_next = NORM_SQUARE;
                    end
                end
                NORM_SQUARE: begin
                    acc_next = acc_reg + NORM_ACC_W'(mag_reg[comp_reg])
                                       * NORM_ACC_W'(mag_reg[comp_reg]);
                    if (comp_reg == 2'd2) begin
                        cnt_next   = '0;
                        sq_next    = '0;
                        state_next = NORM_ROOT;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
                NORM_ROOT: begin
                    sq_next  = sqrt_step(sq_reg.rem, sq_reg.root,
                                         acc_reg[NORM_ACC_W-1 -: 2]);
                    acc_next = acc_reg << 2;
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(NORM_ROOT_N - 1)) begin
                        comp_next  = '0;
                        cnt_next   = '0;
                        num_next   = {mag_reg[0][QUO_W-1:0], {UNIT_FRAC{1'b0}}};
                        drem_next  = '0;
                        quo_next   = '0;
                        state_next = NORM_DIVIDE;
                    end
                end
                NORM_DIVIDE: begin
                    drem_next = qb ? COORD_W'(r2 - {1'b0, sq_reg.root[COORD_W-1:0]})
                                   : r2[COORD_W-1:0];
                    quo_next  = uq;
                    num_next  = num_reg << 1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                        unit_next[comp_reg] = neg_reg[comp_reg] ? -$signed({1'b0, uq})
                                                                : $signed({1'b0, uq});
                        cnt_next  = '0;
                        drem_next = '0;
                        quo_next  = '0;
                        if (comp_reg == 2'd2) begin
                            state_next = NORM_IDLE;
                        end else begin
                            comp_next = comp_reg + 2'd1;
                            num_next  = {mag_reg[comp_reg + 2'd1][QUO_W-1:0],
                                         {UNIT_FRAC{1'b0}}};
                        end
                    end
                end
                default: begin
                    state_next = NORM_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= NORM_IDLE;
            stale_reg <= 1'b1;
            for (int i = 0; i < 3; i++) begin
                unit_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            stale_reg <= stale_next;
            unit_reg  <= unit_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        comp_reg <= comp_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        num_reg  <= num_next;
        drem_reg <= drem_next;
        quo_reg  <= quo_next;
    end

    assign unit.x = unit_reg[0];
    assign unit.y = unit_reg[1];
    assign unit.z = unit_reg[2];
    assign busy   = stale_reg || (state_reg != NORM_IDLE);

endmodule

### sv/pad_front.sv
// ----------------------------------------------------------------------------
// pad_front
// Input side: takes a point beat and forms its offset from the origin.
// ----------------------------------------------------------------------------
module pad_front import pad_pkg::*; (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  vec_t                 origin,
    input  logic                 norm_busy,
    input  logic                 fifo_full,
    output logic                 push,
    output item_t                push_item
);

    logic signed [COORD_W-1:0] px, py, pz;

    assign px = s_tdata[COORD_W-1:0];
    assign py = s_tdata[2*COORD_W-1:COORD_W];
    assign pz = s_tdata[3*COORD_W-1:2*COORD_W];

    // new points wait while the unit axis is being rebuilt
    assign s_tready = !norm_busy && !fifo_full;
    assign push     = s_tvalid && s_tready;

    assign push_item.dx   = DIFF_W'(px) - DIFF_W'(origin.x);
    assign push_item.dy   = DIFF_W'(py) - DIFF_W'(origin.y);
    assign push_item.dz   = DIFF_W'(pz) - DIFF_W'(origin.z);
    assign push_item.last = s_tlast;

endmodule

### sv/pad_fifo.sv
// ----------------------------------------------------------------------------
// pad_fifo
// Short queue between the front and back halves.
// ----------------------------------------------------------------------------
module pad_fifo import pad_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t wr_item,
    input  logic  pop,
    output item_t rd_item,
    output logic  full,
    output logic  empty
);

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### sv/pad_back.sv
// ----------------------------------------------------------------------------
// pad_back
// Arithmetic pipeline: squares and dot product, perpendicular and along terms,
// pipelined square root, saturation and output register.
// ----------------------------------------------------------------------------
module pad_back import pad_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         mode,
    input  vec_t               unit,
    input  item_t              in_item,
    input  logic               fifo_empty,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [COORD_W-1:0] m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    logic adv;

    // stage 1: squares and axis products
    logic                     v1_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg, sqz_reg;
    logic signed [PROD_W-1:0] prx_reg, pry_reg, prz_reg;
    logic                     last1_reg;
    logic [DIFF_W-1:0]        ax, ay, az;

    // stage 2: sums
    logic                     v2_reg;
    logic [SQ_W-1:0]          s_reg;
    logic signed [DOT_W-1:0]  da_reg;
    logic                     last2_reg;

    // stage 3: projection term split for squaring
    logic                     v3_reg;
    logic [RAD_W-1:0]         t_reg;
    logic [GMAG_W-1:0]        pp_hh_reg, pp_hl_reg, pp_ll_reg;
    side_t                    side3_reg;
    logic signed [G_W-1:0]    g;
    logic [G_W-1:0]           gmag;
    logic [GHALF_W-1:0]       gh, gl;
    logic signed [Q_W-1:0]    q;

    // stage 4: radicand
    logic                     v4_reg;
    logic [RAD_W-1:0]         x4_reg, x4_next;
    side_t                    side4_reg;
    logic [G2_W-1:0]          g2, tw;

    // root pipeline
    logic                     rv_reg [SQRT_STEPS];
    sqrt_t                    rs_reg [SQRT_STEPS];
    logic [RAD_W-1:0]         rx_reg [SQRT_STEPS];
    side_t                    rside_reg [SQRT_STEPS];

    // output
    logic                     m_valid_reg;
    logic [COORD_W-1:0]       m_data_reg, m_data_next;
    logic                     m_sat_reg, m_sat_next;
    logic                     m_last_reg;
    logic [ROOT_W-GUARD_BITS-1:0] rad;
    logic                     rad_sat;

    assign adv = !m_valid_reg || m_tready;
    assign pop = adv && !fifo_empty;

    assign ax = diff_mag(in_item.dx);
    assign ay = diff_mag(in_item.dy);
    assign az = diff_mag(in_item.dz);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx_reg   <= SQ_W'(ax) * SQ_W'(ax);
            sqy_reg   <= SQ_W'(ay) * SQ_W'(ay);
            sqz_reg   <= SQ_W'(az) * SQ_W'(az);
            prx_reg   <= PROD_W'(in_item.dx) * PROD_W'(unit.x);
            pry_reg   <= PROD_W'(in_item.dy) * PROD_W'(unit.y);
            prz_reg   <= PROD_W'(in_item.dz) * PROD_W'(unit.z);
            last1_reg <= in_item.last;

            s_reg     <= sqx_reg + sqy_reg + sqz_reg;
            da_reg    <= DOT_W'(prx_reg) + DOT_W'(pry_reg) + DOT_W'(prz_reg);
            last2_reg <= last1_reg;
        end
    end

    assign g    = da_reg[DOT_W-1:G_SHIFT];
    assign gmag = g[G_W-1] ? G_W'(-g) : G_W'(g);
    assign gh   = gmag[GMAG_W-1:GHALF_W];
    assign gl   = gmag[GHALF_W-1:0];
    assign q    = da_reg[DOT_W-1:UNIT_FRAC];

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg     <= {s_reg, {(2*GUARD_BITS){1'b0}}};
            pp_hh_reg <= GMAG_W'(gh) * GMAG_W'(gh);
            pp_hl_reg <= GMAG_W'(gh) * GMAG_W'(gl);
            pp_ll_reg <= GMAG_W'(gl) * GMAG_W'(gl);
            side3_reg.last <= last2_reg;
            if (q > Q_W'(DIST_MAX)) begin
                side3_reg.along     <= DIST_MAX;
                side3_reg.along_sat <= 1'b1;
            end else if (q < Q_W'(DIST_MIN)) begin
                side3_reg.along     <= DIST_MIN;
                side3_reg.along_sat <= 1'b1;
            end else begin
                side3_reg.along     <= q[COORD_W-1:0];
                side3_reg.along_sat <= 1'b0;
            end
        end
    end

    always_comb begin
        g2 = (G2_W'(pp_hh_reg) << (2 * GHALF_W)) + (G2_W'(pp_hl_reg) << (GHALF_W + 1))
           + G2_W'(pp_ll_reg);
        tw = G2_W'(t_reg);
        unique case (mode)
            MODE_ORIGIN: x4_next = t_reg;
            MODE_PERP:   x4_next = (tw >= g2) ? RAD_W'(tw - g2) : '0;
            default:     x4_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x4_reg    <= x4_next;
            side4_reg <= side3_reg;
            rs_reg[0]    <= sqrt_step('0, '0, x4_reg[RAD_W-1 -: 2]);
            rx_reg[0]    <= x4_reg << 2;
            rside_reg[0] <= side4_reg;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                rs_reg[k]    <= sqrt_step(rs_reg[k-1].rem, rs_reg[k-1].root,
                                          rx_reg[k-1][RAD_W-1 -: 2]);
                rx_reg[k]    <= rx_reg[k-1] << 2;
                rside_reg[k] <= rside_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                rv_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg    <= pop;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            rv_reg[0] <= v4_reg;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                rv_reg[k] <= rv_reg[k-1];
            end
            m_valid_reg <= rv_reg[SQRT_STEPS-1];
        end
    end

    assign rad     = rs_reg[SQRT_STEPS-1].root[ROOT_W-1:GUARD_BITS];
    assign rad_sat = |rad[ROOT_W-GUARD_BITS-1:COORD_W-1];

    always_comb begin
        unique case (mode)
            MODE_ORIGIN, MODE_PERP: begin
                m_data_next = rad_sat ? DIST_MAX : rad[COORD_W-1:0];
                m_sat_next  = rad_sat;
            end
            MODE_ALONG: begin
                m_data_next = rside_reg[SQRT_STEPS-1].along;
                m_sat_next  = rside_reg[SQRT_STEPS-1].along_sat;
            end
            default: begin
                m_data_next = '0;
                m_sat_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
            m_sat_reg  <= m_sat_next;
            m_last_reg <= rside_reg[SQRT_STEPS-1].last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;
    assign m_tlast  = m_last_reg;

endmodule

### sv/point_axis_distance.sv
// ----------------------------------------------------------------------------
// point_axis_distance
// 3D point to origin / axis distance in signed Q16.16, stream in, stream out.
// ----------------------------------------------------------------------------
// An accepted input beat reaches its result beat through the queue pop,
// four arithmetic stages, a 41-stage square root and the output reg.
// Throughput: one beat per cycle; the whole back pipeline stalls together
// when the output beat is not taken, and the 4-entry queue absorbs the front.
// After reset, and after any register write, the unit axis is rebuilt by a
// sequential normaliser while s_tready is held low.
// Reset (aresetn, synchronous): mode 0, origin 0, axis (0,0,1.0), queue empty.
// ----------------------------------------------------------------------------
module point_axis_distance import pad_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_wdata,
    // point beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // point_x, point_y, point_z
    input  logic                 s_tlast,   // last_point
    // distance beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [COORD_W-1:0]   m_tdata,   // distance
    output logic                 m_tuser,   // saturated
    output logic                 m_tlast    // last_result
);

    logic [1:0] mode_reg;
    vec_t       origin_reg;
    vec_t       axis_reg;
    vec_t       unit;
    logic       norm_busy;
    logic       restart;

    logic       push, pop, fifo_full, fifo_empty;
    item_t      push_item, pop_item;

    // any write to a real register invalidates the unit axis
    assign restart = cfg_wr_en && (cfg_index <= REG_AXIS_Z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_ORIGIN;
            origin_reg <= '0;
            axis_reg.x <= '0;
            axis_reg.y <= '0;
            axis_reg.z <= AXIS_Z_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_wdata[1:0];
                REG_ORIGIN_X: origin_reg.x <= cfg_wdata;
                REG_ORIGIN_Y: origin_reg.y <= cfg_wdata;
                REG_ORIGIN_Z: origin_reg.z <= cfg_wdata;
                REG_AXIS_X:   axis_reg.x   <= cfg_wdata;
                REG_AXIS_Y:   axis_reg.y   <= cfg_wdata;
                REG_AXIS_Z:   axis_reg.z   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // axis normaliser: Q2.30 unit vector, zero for a zero-length axis
    pad_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart),
        .axis    (axis_reg),
        .unit    (unit),
        .busy    (norm_busy)
    );

    // front: accept beat, offset from origin
    pad_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .origin    (origin_reg),
        .norm_busy (norm_busy),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    pad_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_item (push_item),
        .pop     (pop),
        .rd_item (pop_item),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    // back: arithmetic pipeline and output register
    pad_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mode       (mode_reg),
        .unit       (unit),
        .in_item    (pop_item),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // a register write must close the input until the axis is rebuilt
    a_write_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> !s_tready)
        else $error("input open right after a register write");

    // unused mode gives a zero, unsaturated distance
    a_unused_mode_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && mode_reg == MODE_UNUSED) |-> (m_tdata == '0 && !m_tuser))
        else $error("unused mode produced a non-zero beat");

    // root modes only saturate at the positive limit
    a_root_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser && (mode_reg == MODE_ORIGIN || mode_reg == MODE_PERP))
        |-> (m_tdata == DIST_MAX))
        else $error("saturated distance not at positive limit");

endmodule
